// ===== src/ncf_pkg.sv =====
`timescale 1ns / 1ps

package ncf_pkg;

   // fixed field widths
   localparam int PIX_W      = 12;
   localparam int IMG_W_W    = 13;
   localparam int ZOOM_W     = 55;
   localparam int OFF_W      = 56;
   localparam int RGBA_W     = 32;
   localparam int ITER_OUT_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 56;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // datapath widths
   localparam int Q_W    = 64;
   localparam int WIDE_W = 128;
   localparam int ACC_W  = 129;
   // quotient bits kept by the divider (pixel * zoom fits in 67 bits)
   localparam int QUO_W  = 68;

   localparam logic signed [Q_W-1:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   // defaults for top level parameters
   localparam int MAX_ITERATIONS_DEF = 150;
   localparam int FRAC_BITS_DEF      = 40;
   localparam int MAX_WIDTH_DEF      = 4096;

   // register reset values
   localparam logic [IMG_W_W-1:0] WIDTH_RESET   = 13'd800;
   localparam logic [ZOOM_W-1:0]  ZOOM_RESET    = 55'd4398046511104;
   localparam logic [OFF_W-1:0]   OFFSET_RESET  = 56'hFF_FE00_0000_0000;
   localparam logic [RGBA_W-1:0]  COL_ONE_RESET = 32'hE629_37FF;
   localparam logic [RGBA_W-1:0]  COL_TWO_RESET = 32'h0079_F1FF;
   localparam logic [RGBA_W-1:0]  COL_THR_RESET = 32'h00E4_30FF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH     = 3'd0,
      REG_ZOOM      = 3'd1,
      REG_OFF_RE    = 3'd2,
      REG_OFF_IM    = 3'd3,
      REG_COL_ONE   = 3'd4,
      REG_COL_TWO   = 3'd5,
      REG_COL_THREE = 3'd6
   } csr_index_type;

   // one signed product request for the shared multiplier
   typedef struct packed {
      logic signed [Q_W-1:0] a;
      logic signed [Q_W-1:0] b;
      logic                  neg;
   } mac_op_type;

   // float32 brightness factors as mantissa and exponent
   function automatic logic [23:0] band_mant(input logic [2:0] k);
      case (k)
         3'd0:    return 24'hCCCCCD;
         3'd1:    return 24'h99999A;
         3'd2:    return 24'hCCCCCD;
         3'd3:    return 24'h800000;
         3'd4:    return 24'h99999A;
         3'd5:    return 24'hB33333;
         default: return 24'hF33333;
      endcase
   endfunction

   function automatic logic [4:0] band_exp(input logic [2:0] k);
      case (k)
         3'd0:    return 5'd27;
         3'd1:    return 5'd25;
         3'd2:    return 5'd25;
         default: return 5'd24;
      endcase
   endfunction

   function automatic int band_above(input logic [2:0] i);
      case (i)
         3'd0:    return 90;
         3'd1:    return 70;
         3'd2:    return 55;
         3'd3:    return 40;
         3'd4:    return 25;
         default: return 10;
      endcase
   endfunction

   // channel times factor, rounded to 24 significant bits, then truncated
   function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [2:0] k);
      logic [31:0] p;
      logic [31:0] keep;
      logic [31:0] rem;
      logic [31:0] half;
      logic [32:0] r;
      logic [3:0]  s;
      p = {24'b0, c} * {8'b0, band_mant(k)};
      s = 4'd0;
      for (int i = 1; i <= 8; i++) begin
         if ((p >> (23 + i)) != 32'd0) s = 4'(i);
      end
      if (s != 4'd0) begin
         keep = p >> s;
         rem  = p & ((32'd1 << s) - 32'd1);
         half = 32'd1 << (s - 4'd1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 32'd1;
         r = {1'b0, keep} << s;
      end else begin
         r = {1'b0, p};
      end
      r = r >> band_exp(k);
      return r[7:0];
   endfunction

endpackage

// ===== src/newton_cubic_fractal_pixel_core.sv =====
`timescale 1ns / 1ps

// newton fractal pixel core for z^3 - 1
// req channel: one transaction per pixel, tdata = {pixel_row, pixel_col}
// rsp channel: one transaction per pixel, tdata = {iterations_used, pixel_rgba}
// csr channel: register writes (index, data), always ready; write only while idle
// each pixel is mapped to the complex plane (one multiply pass and one divide per
// axis), then newton steps run until the step is small or the iteration limit hits
// mapping is two multiply passes and two serial divides; each newton step is nine
// multiply passes on the shared 32x32 multiplier plus two serial divides; after the
// last step come three root distance passes and the shade step; the next pixel is
// taken once the sequencer is back in idle
// one pixel is in work at a time; req_tready is high only while the sequencer idles
// the finished result sits in an output register, so a new pixel is taken while the
// receiver stalls; a second result waits in the shade step until rsp drains
// reset clears the sequencer and output valid and loads the register defaults
// (width 800, zoom 4.0, offsets -2.0, the three root colors)
module newton_cubic_fractal_pixel_core
   import ncf_pkg::*;
#(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel_col [11:0], pixel_row [23:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pixel_rgba [31:0], iterations_used [39:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int DVW  = WIDE_W + FRAC_BITS;

   localparam logic signed [Q_W-1:0] Q_ONE  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [Q_W-1:0] Q_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [Q_W-1:0] Q_TINY =
      ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
   localparam logic [Q_W-1:0] Q_NEAR =
      ((64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
   localparam logic [Q_W-1:0] Q_ROOT_IM =
      (64'd866 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [WIDE_W-1:0] TOL2 = WIDE_W'(Q_TINY) * WIDE_W'(Q_TINY);
   localparam logic [WIDE_W-1:0] LIM2 = WIDE_W'(Q_NEAR) * WIDE_W'(Q_NEAR);

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_MAP_X  = 20'h00002,
      S_DIV_X  = 20'h00004,
      S_MAP_Y  = 20'h00008,
      S_DIV_Y  = 20'h00010,
      S_NEAR   = 20'h00020,
      S_SQ_RE  = 20'h00040,
      S_SQ_IM  = 20'h00080,
      S_CU_RE  = 20'h00100,
      S_CU_IM  = 20'h00200,
      S_DEN    = 20'h00400,
      S_NUM_RE = 20'h00800,
      S_DIV_RE = 20'h01000,
      S_NUM_IM = 20'h02000,
      S_DIV_IM = 20'h04000,
      S_STEP   = 20'h08000,
      S_ERR_1  = 20'h10000,
      S_ERR_2  = 20'h20000,
      S_ERR_3  = 20'h40000,
      S_SHADE  = 20'h80000
   } state_type;

   // configuration registers
   logic [IMG_W_W-1:0]      width_ff;
   logic [ZOOM_W-1:0]       zoom_ff;
   logic signed [OFF_W-1:0] off_re_ff;
   logic signed [OFF_W-1:0] off_im_ff;
   logic [RGBA_W-1:0]       col_one_ff;
   logic [RGBA_W-1:0]       col_two_ff;
   logic [RGBA_W-1:0]       col_thr_ff;

   // sequencer and working registers
   state_type               state_ff, state_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [PIX_W-1:0]        pcol_ff, pcol_in;
   logic [PIX_W-1:0]        prow_ff, prow_in;
   logic [IT_W-1:0]         iter_ff, iter_in;
   logic signed [Q_W-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [Q_W-1:0]   ar_ff, ar_in, ai_ff, ai_in;
   logic signed [Q_W-1:0]   nr_ff, nr_in, ni_ff, ni_in;
   logic signed [Q_W-1:0]   dr_ff, dr_in, di_ff, di_in;
   logic signed [Q_W-1:0]   sr_ff, sr_in;
   logic [WIDE_W-1:0]       den_ff, den_in;
   logic [WIDE_W-1:0]       num_ff, num_in;
   logic                    nneg_ff, nneg_in;
   logic [WIDE_W-1:0]       e1_ff, e1_in, e2_ff, e2_in;
   logic [RGBA_W-1:0]       color_ff, color_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // shared units
   logic                    mac_phase;
   logic                    mac_done;
   logic                    mac_clr;
   logic                    mac_issue;
   mac_op_type              op0, op1, mac_op;
   logic signed [ACC_W-1:0] acc;
   logic [WIDE_W-1:0]       acc_mag;
   logic signed [Q_W-1:0]   acc_q;
   logic                    map_phase;
   logic                    div_start;
   logic                    div_done;
   logic [DVW-1:0]          div_dvd;
   logic [WIDE_W-1:0]       div_dsr;
   logic [QUO_W-1:0]        div_quo;
   logic                    div_over;
   logic signed [Q_W-1:0]   step_q;
   logic [WW-1:0]           w_eff;
   logic [2:0]              band;
   logic                    go;
   logic [7:0]              ch_r, ch_g, ch_b;

   function automatic mac_op_type mk(input logic signed [Q_W-1:0] a,
                                     input logic signed [Q_W-1:0] b,
                                     input logic neg);
      mac_op_type o;
      o.a   = a;
      o.b   = b;
      o.neg = neg;
      return o;
   endfunction

   // clamp to the symmetric q range
   function automatic logic signed [Q_W-1:0] sat66(input logic signed [65:0] v);
      if (v > 66'(Q_MAX)) return Q_MAX;
      if (v < -66'(Q_MAX)) return -Q_MAX;
      return v[Q_W-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
      return sat66(66'(a) - 66'(b));
   endfunction

   function automatic logic signed [Q_W-1:0] sat3(input logic signed [Q_W-1:0] a);
      return sat66(66'(a) + 66'(a) + 66'(a));
   endfunction

   // map pixel quotient plus offset, upper clamp only
   function automatic logic signed [Q_W-1:0] map_add(input logic [QUO_W-1:0] q,
                                                      input logic signed [OFF_W-1:0] o);
      logic signed [QUO_W+1:0] s;
      s = signed'({2'b00, q}) + (QUO_W+2)'(o);
      if (s > (QUO_W+2)'(Q_MAX)) return Q_MAX;
      return s[Q_W-1:0];
   endfunction

   ncf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .clr   (mac_clr),
      .issue (mac_issue),
      .part  (cnt_ff[1:0]),
      .op    (mac_op),
      .acc   (acc)
   );

   ncf_div #(
      .DVW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quo      (div_quo),
      .over     (div_over)
   );

   // operand selection for the two products of each pass
   always_comb begin
      op0 = '0;
      op1 = '0;
      case (state_ff)
         S_MAP_X:  op0 = mk(Q_W'(pcol_ff), Q_W'(zoom_ff), 1'b0);
         S_MAP_Y:  op0 = mk(Q_W'(prow_ff), Q_W'(zoom_ff), 1'b0);
         S_NEAR: begin
            op0 = mk(zr_ff, zr_ff, 1'b0);
            op1 = mk(zi_ff, zi_ff, 1'b0);
         end
         S_SQ_RE: begin
            op0 = mk(zr_ff, zr_ff, 1'b0);
            op1 = mk(zi_ff, zi_ff, 1'b1);
         end
         S_SQ_IM: begin
            op0 = mk(zr_ff, zi_ff, 1'b0);
            op1 = mk(zi_ff, zr_ff, 1'b0);
         end
         S_CU_RE: begin
            op0 = mk(ar_ff, zr_ff, 1'b0);
            op1 = mk(ai_ff, zi_ff, 1'b1);
         end
         S_CU_IM: begin
            op0 = mk(ar_ff, zi_ff, 1'b0);
            op1 = mk(ai_ff, zr_ff, 1'b0);
         end
         S_DEN, S_ERR_2: begin
            op0 = mk(dr_ff, dr_ff, 1'b0);
            op1 = mk(di_ff, di_ff, 1'b0);
         end
         S_NUM_RE: begin
            op0 = mk(nr_ff, dr_ff, 1'b0);
            op1 = mk(ni_ff, di_ff, 1'b0);
         end
         S_NUM_IM: begin
            op0 = mk(ni_ff, dr_ff, 1'b0);
            op1 = mk(nr_ff, di_ff, 1'b1);
         end
         S_STEP: begin
            op0 = mk(sr_ff, sr_ff, 1'b0);
            op1 = mk(ni_ff, ni_ff, 1'b0);
         end
         S_ERR_1: begin
            op0 = mk(ar_ff, ar_ff, 1'b0);
            op1 = mk(ai_ff, ai_ff, 1'b0);
         end
         S_ERR_3: begin
            op0 = mk(dr_ff, dr_ff, 1'b0);
            op1 = mk(nr_ff, nr_ff, 1'b0);
         end
         default: begin
            op0 = '0;
            op1 = '0;
         end
      endcase
      mac_op = cnt_ff[2] ? op1 : op0;
   end

   // datapath helpers
   always_comb begin
      mac_phase = state_ff inside {S_MAP_X, S_MAP_Y, S_NEAR, S_SQ_RE, S_SQ_IM, S_CU_RE,
                                   S_CU_IM, S_DEN, S_NUM_RE, S_NUM_IM, S_STEP, S_ERR_1,
                                   S_ERR_2, S_ERR_3};
      map_phase = state_ff inside {S_DIV_X, S_DIV_Y};
      mac_clr   = mac_phase && cnt_ff == 4'd0;
      mac_issue = mac_phase && !cnt_ff[3];
      mac_done  = mac_phase && cnt_ff == 4'd9;
      div_start = (state_ff inside {S_DIV_X, S_DIV_Y, S_DIV_RE, S_DIV_IM}) &&
                  cnt_ff == 4'd0;

      acc_mag = acc[ACC_W-1] ? WIDE_W'(-acc) : WIDE_W'(acc);
      // floor shift by the fraction bits, clamped
      acc_q   = sat66(66'(acc >>> FRAC_BITS) > 66'(Q_MAX) ? 66'(Q_MAX) :
                      66'(acc >>> FRAC_BITS));
      if ((acc >>> FRAC_BITS) > ACC_W'(Q_MAX)) acc_q = Q_MAX;
      else if ((acc >>> FRAC_BITS) < -ACC_W'(Q_MAX)) acc_q = -Q_MAX;
      else acc_q = Q_W'(acc >>> FRAC_BITS);

      if (width_ff == '0) w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);

      div_dvd = map_phase ? DVW'(num_ff) : {num_ff, {FRAC_BITS{1'b0}}};
      div_dsr = map_phase ? WIDE_W'(w_eff) : den_ff;

      // newton quotient, magnitude saturated, sign of numerator
      if (div_over || div_quo[QUO_W-1:Q_W-1] != '0) step_q = Q_MAX;
      else step_q = signed'({1'b0, div_quo[Q_W-2:0]});
      if (nneg_ff) step_q = -step_q;

      go = (TOL2 < acc[WIDE_W-1:0]) && (iter_ff < IT_W'(MAX_ITERATIONS));

      // iteration band, first threshold exceeded wins
      band = 3'd6;
      for (int i = 5; i >= 0; i--) begin
         if (int'(iter_ff) > band_above(3'(i))) band = 3'(i);
      end
      ch_r = scale_chan(color_ff[31:24], band);
      ch_g = scale_chan(color_ff[23:16], band);
      ch_b = scale_chan(color_ff[15:8], band);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pcol_in      = pcol_ff;
      prow_in      = prow_ff;
      iter_in      = iter_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      ar_in        = ar_ff;
      ai_in        = ai_ff;
      nr_in        = nr_ff;
      ni_in        = ni_ff;
      dr_in        = dr_ff;
      di_in        = di_ff;
      sr_in        = sr_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      nneg_in      = nneg_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      // pass counter: issue phase, then a drain, then the result
      if (mac_phase) cnt_in = mac_done ? 4'd0 : cnt_ff + 4'd1;
      if (div_start) cnt_in = 4'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pcol_in  = req_tdata[PIX_W-1:0];
               prow_in  = req_tdata[2*PIX_W-1:PIX_W];
               iter_in  = '0;
               cnt_in   = 4'd0;
               state_in = S_MAP_X;
            end
         end
         S_MAP_X: begin
            if (mac_done) begin
               num_in   = acc[WIDE_W-1:0];
               state_in = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               zr_in    = map_add(div_quo, off_re_ff);
               cnt_in   = 4'd0;
               state_in = S_MAP_Y;
            end
         end
         S_MAP_Y: begin
            if (mac_done) begin
               num_in   = acc[WIDE_W-1:0];
               state_in = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               zi_in    = map_add(div_quo, off_im_ff);
               cnt_in   = 4'd0;
               state_in = S_NEAR;
            end
         end
         S_NEAR: begin
            if (mac_done) begin
               // start point too close to zero is nudged off it
               if (acc[WIDE_W-1:0] < LIM2) begin
                  zr_in = signed'(Q_TINY);
                  zi_in = signed'(Q_TINY);
               end
               state_in = S_SQ_RE;
            end
         end
         S_SQ_RE: begin
            if (mac_done) begin
               ar_in    = acc_q;
               state_in = S_SQ_IM;
            end
         end
         S_SQ_IM: begin
            if (mac_done) begin
               ai_in    = acc_q;
               state_in = S_CU_RE;
            end
         end
         S_CU_RE: begin
            if (mac_done) begin
               nr_in    = sat_sub(acc_q, Q_ONE);
               state_in = S_CU_IM;
            end
         end
         S_CU_IM: begin
            if (mac_done) begin
               ni_in    = acc_q;
               dr_in    = sat3(ar_ff);
               di_in    = sat3(ai_ff);
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (mac_done) begin
               den_in   = acc[WIDE_W-1:0];
               state_in = S_NUM_RE;
            end
         end
         S_NUM_RE: begin
            if (mac_done) begin
               num_in   = acc_mag;
               nneg_in  = acc[ACC_W-1];
               state_in = S_DIV_RE;
            end
         end
         S_DIV_RE: begin
            if (div_done) begin
               sr_in    = step_q;
               cnt_in   = 4'd0;
               state_in = S_NUM_IM;
            end
         end
         S_NUM_IM: begin
            if (mac_done) begin
               num_in   = acc_mag;
               nneg_in  = acc[ACC_W-1];
               state_in = S_DIV_IM;
            end
         end
         S_DIV_IM: begin
            if (div_done) begin
               // imaginary step parked in ni for the step size pass
               ni_in    = step_q;
               zr_in    = sat_sub(zr_ff, sr_ff);
               zi_in    = sat_sub(zi_ff, step_q);
               iter_in  = iter_ff + IT_W'(1);
               cnt_in   = 4'd0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (mac_done) begin
               if (go) begin
                  state_in = S_NEAR;
               end else begin
                  // distances to the three roots
                  ar_in    = sat_sub(Q_ONE, zr_ff);
                  ai_in    = sat_sub('0, zi_ff);
                  dr_in    = sat_sub(-Q_HALF, zr_ff);
                  di_in    = sat_sub(signed'(Q_ROOT_IM), zi_ff);
                  nr_in    = sat_sub(-signed'(Q_ROOT_IM), zi_ff);
                  state_in = S_ERR_1;
               end
            end
         end
         S_ERR_1: begin
            if (mac_done) begin
               e1_in    = acc[WIDE_W-1:0];
               state_in = S_ERR_2;
            end
         end
         S_ERR_2: begin
            if (mac_done) begin
               e2_in    = acc[WIDE_W-1:0];
               state_in = S_ERR_3;
            end
         end
         S_ERR_3: begin
            if (mac_done) begin
               if (e1_ff < e2_ff && e1_ff < acc[WIDE_W-1:0]) color_in = col_one_ff;
               else if (e2_ff < e1_ff && e2_ff < acc[WIDE_W-1:0]) color_in = col_two_ff;
               else color_in = col_thr_ff;
               state_in = S_SHADE;
            end
         end
         S_SHADE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ITER_OUT_W'(iter_ff), ch_r, ch_g, ch_b, color_ff[7:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         zoom_ff      <= ZOOM_RESET;
         off_re_ff    <= OFFSET_RESET;
         off_im_ff    <= OFFSET_RESET;
         col_one_ff   <= COL_ONE_RESET;
         col_two_ff   <= COL_TWO_RESET;
         col_thr_ff   <= COL_THR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_WIDTH:     width_ff   <= csr_data[IMG_W_W-1:0];
               REG_ZOOM:      zoom_ff    <= csr_data[ZOOM_W-1:0];
               REG_OFF_RE:    off_re_ff  <= csr_data[OFF_W-1:0];
               REG_OFF_IM:    off_im_ff  <= csr_data[OFF_W-1:0];
               REG_COL_ONE:   col_one_ff <= csr_data[RGBA_W-1:0];
               REG_COL_TWO:   col_two_ff <= csr_data[RGBA_W-1:0];
               REG_COL_THREE: col_thr_ff <= csr_data[RGBA_W-1:0];
               default: ;
            endcase
         end
      end
      pcol_ff     <= pcol_in;
      prow_ff     <= prow_in;
      iter_ff     <= iter_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      ar_ff       <= ar_in;
      ai_ff       <= ai_in;
      nr_ff       <= nr_in;
      ni_ff       <= ni_in;
      dr_ff       <= dr_in;
      di_ff       <= di_in;
      sr_ff       <= sr_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      nneg_ff     <= nneg_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// ===== src/ncf_mac.sv =====
`timescale 1ns / 1ps

// signed 64x64 multiply-accumulate, one 32x32 partial product per cycle
module ncf_mac
   import ncf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clr,
   input  logic                    issue,
   input  logic [1:0]              part,
   input  mac_op_type              op,
   output logic signed [ACC_W-1:0] acc
);

   logic [Q_W-1:0]          a_mag;
   logic [Q_W-1:0]          b_mag;
   logic [31:0]             a_part;
   logic [31:0]             b_part;
   logic [63:0]             pp_ff, pp_in;
   logic [1:0]              sh_ff, sh_in;
   logic                    neg_ff, neg_in;
   logic                    ppv_ff, ppv_in;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      a_mag  = op.a[Q_W-1] ? Q_W'(-op.a) : Q_W'(op.a);
      b_mag  = op.b[Q_W-1] ? Q_W'(-op.b) : Q_W'(op.b);
      a_part = a_mag[{part[0], 5'd0} +: 32];
      b_part = b_mag[{part[1], 5'd0} +: 32];
      pp_in  = {32'b0, a_part} * {32'b0, b_part};
      sh_in  = {1'b0, part[0]} + {1'b0, part[1]};
      neg_in = op.a[Q_W-1] ^ op.b[Q_W-1] ^ op.neg;
      ppv_in = issue;
      // partial product placed at its weight, signed
      term   = signed'({65'b0, pp_ff}) <<< {sh_ff, 5'd0};
      if (neg_ff) term = -term;
      if (clr) acc_in = '0;
      else if (ppv_ff) acc_in = acc_ff + term;
      else acc_in = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppv_ff <= 1'b0;
      end else begin
         ppv_ff <= ppv_in;
      end
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== src/ncf_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ncf_div
   import ncf_pkg::*;
#(
   parameter int DVW = WIDE_W + FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVW-1:0]    dividend,
   input  logic [WIDE_W-1:0] divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quo,
   output logic              over
);

   localparam int CNT_W = $clog2(DVW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [WIDE_W-1:0] dsr_ff, dsr_in;
   logic [DVW-1:0]    dvd_ff, dvd_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              over_ff, over_in;
   logic [WIDE_W:0]   r2;
   logic [WIDE_W:0]   diff;
   logic              take;

   always_comb begin
      r2      = {rem_ff, dvd_ff[DVW-1]};
      diff    = r2 - {1'b0, dsr_ff};
      take    = r2 >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      over_in = over_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVW);
         rem_in  = '0;
         dsr_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
         over_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = take ? diff[WIDE_W-1:0] : r2[WIDE_W-1:0];
         dvd_in  = {dvd_ff[DVW-2:0], 1'b0};
         over_in = over_ff | quo_ff[QUO_W-1];
         quo_in  = {quo_ff[QUO_W-2:0], take};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      over_ff <= over_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign over = over_ff;

endmodule
